// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; every macro samples on clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/coewma_pkg.sv -----
// ----------------------------------------------------------------------------
// coewma_pkg
// Shared widths, constants, arctangent table and control structs for the
// circular offset EWMA filter.
// ----------------------------------------------------------------------------
package coewma_pkg;

  // port field widths
  localparam int ANGLE_FIELD_W = 16;
  localparam int DECAY_W       = 16;

  // parameter defaults
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // decay factor, unsigned Q1.15
  localparam logic [DECAY_W-1:0] DECAY_ONE   = 16'd32768;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd31130;

  // CORDIC datapath widths: x/y hold the atan2 operands scaled by 2^16 plus
  // gain headroom, z holds a 32-bit phase plus sign and guard bit
  localparam int CORDIC_W = 52;
  localparam int ZW       = 34;
  localparam int ATAN_IDX_W = 5;

  // rotation start vector, 2^30 times the inverse CORDIC gain
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 52'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] r;
    begin
      unique case (idx)
        5'd0:  r = 32'h20000000;
        5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;
        5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;
        5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;
        5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;
        5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;
        5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;
        5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;
        5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;
        5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;
        5'd23: r = 32'h00000051;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction

  // sequencer to CORDIC engine
  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  // CORDIC engine to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

endpackage

// ----- src/coewma_cordic.sv -----
// ----------------------------------------------------------------------------
// coewma_cordic
// Shared iterative CORDIC engine, one micro-rotation per cycle, used in
// rotation mode for sine/cosine and in vectoring mode for atan2.
// ----------------------------------------------------------------------------
module coewma_cordic #(
  parameter int CORDIC_STEPS = coewma_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  coewma_pkg::cordic_ctl_t                 ctl,
  input  logic signed [coewma_pkg::CORDIC_W-1:0]  x_init,
  input  logic signed [coewma_pkg::CORDIC_W-1:0]  y_init,
  input  logic signed [coewma_pkg::ZW-1:0]        z_init,
  output coewma_pkg::cordic_sts_t                 sts,
  output logic signed [coewma_pkg::CORDIC_W-1:0]  x_out,
  output logic signed [coewma_pkg::CORDIC_W-1:0]  y_out,
  output logic signed [coewma_pkg::ZW-1:0]        z_out
);
  import coewma_pkg::*;

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic signed [CORDIC_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ZW-1:0]       z_r, z_nxt;
  logic [STEP_W-1:0]          cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt, done_r, done_nxt, vec_r, vec_nxt;

  logic signed [CORDIC_W-1:0] x_sh, y_sh;
  logic signed [ZW-1:0]       atan_z;
  logic                       sigma;

  // one micro-rotation: shifted cross terms and table angle
  always_comb begin
    x_sh   = x_r >>> cnt_r;
    y_sh   = y_r >>> cnt_r;
    atan_z = $signed({2'b00, atan_turn(ATAN_IDX_W'(cnt_r))});
    // sigma high: rotate positive (x -= y', y += x', z -= a)
    if (vec_r) begin
      sigma = !(!y_r[CORDIC_W-1] && (y_r != '0));
    end else begin
      sigma = !z_r[ZW-1];
    end
  end

  // sequencing of the iterations
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    vec_nxt  = vec_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      x_nxt    = x_init;
      y_nxt    = y_init;
      z_nxt    = z_init;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      vec_nxt  = ctl.vectoring;
    end else if (busy_r) begin
      if (sigma) begin
        x_nxt = x_r - y_sh;
        y_nxt = y_r + x_sh;
        z_nxt = z_r - atan_z;
      end else begin
        x_nxt = x_r + y_sh;
        y_nxt = y_r - x_sh;
        z_nxt = z_r + atan_z;
      end
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      vec_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      vec_r  <= vec_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;

endmodule

// ----- src/circular_offset_ewma_filter_unit.sv -----
// ----------------------------------------------------------------------------
// circular_offset_ewma_filter_unit
// Tracks the angular offset b in y = x + b (mod one turn) as an exponentially
// weighted circular mean of y - x.
// ----------------------------------------------------------------------------
// Usage: in_kind 0 is an update with x and y, 1 a predict from x alone. Each
//   item gives one result (out_valid/out_ready): the intercept and x plus the
//   intercept. cfg_valid/cfg_ready writes the Q1.15 decay factor; values
//   above 1.0 are clamped. cfg_ready is always high.
// Timing: one CORDIC engine, one micro-rotation per cycle, and one 32x17
//   multiplier used twice. An update runs a rotation pass, the decay
//   multiply and add for the sine sum, then for the cosine sum, and a
//   vectoring pass; a predict runs the vectoring pass only. With both sums
//   zero the vectoring pass is skipped. in_ready is high only while idle,
//   so a new item is taken only after the last one has gone to the output.
// Reset: sums cleared, decay back to 0.95, both channels empty.
// Stall: a finished result waits in the output register; the next item can
//   be accepted meanwhile, and its own result waits until the first is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_offset_ewma_filter_unit #(
  parameter int ANGLE_BITS   = coewma_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = coewma_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // config write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [coewma_pkg::DECAY_W-1:0]       cfg_decay,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [coewma_pkg::ANGLE_FIELD_W-1:0] in_x_angle,
  input  logic [coewma_pkg::ANGLE_FIELD_W-1:0] in_y_angle,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [coewma_pkg::ANGLE_FIELD_W-1:0] out_intercept,
  output logic [coewma_pkg::ANGLE_FIELD_W-1:0] out_predicted_y
);
  import coewma_pkg::*;

  localparam int AB      = ANGLE_BITS;
  localparam int SUM_W   = 32;
  localparam int TERM_W  = 17;
  localparam int PROD_W  = SUM_W + TERM_W;
  localparam logic [31:0] ICPT_ROUND = 32'd1 << (31 - AB);

  localparam logic signed [PROD_W-1:0] SUM_MAX = 49'sd2147483647;
  localparam logic signed [PROD_W-1:0] SUM_MIN = -49'sd2147483648;

  // sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ROT    = 4'd1;
  localparam logic [3:0] ST_MUL_S  = 4'd2;
  localparam logic [3:0] ST_ADD_S  = 4'd3;
  localparam logic [3:0] ST_MUL_C  = 4'd4;
  localparam logic [3:0] ST_ADD_C  = 4'd5;
  localparam logic [3:0] ST_VSTART = 4'd6;
  localparam logic [3:0] ST_VEC    = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  logic [3:0] state_r, state_nxt;

  logic [DECAY_W-1:0]         decay_r, decay_nxt;
  logic signed [SUM_W-1:0]    sine_sum_r, sine_sum_nxt, cosine_sum_r, cosine_sum_nxt;
  logic signed [TERM_W-1:0]   s_term_r, s_term_nxt, c_term_r, c_term_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic [AB-1:0]              xa_r, xa_nxt, icpt_r, icpt_nxt;
  logic                       flip_r, flip_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [ANGLE_FIELD_W-1:0]   out_icpt_r, out_icpt_nxt, out_pred_r, out_pred_nxt;

  cordic_ctl_t                cordic_ctl;
  cordic_sts_t                cordic_sts;
  logic signed [CORDIC_W-1:0] cx_init, cy_init, cx_out, cy_out;
  logic signed [ZW-1:0]       cz_init, cz_out;

  logic                       in_acc;
  logic [31:0]                x_wide, y_wide, icpt_wide, pred_wide, z_round;
  logic [AB-1:0]              x_in, y_in, diff, pred_sum;
  logic signed [ZW-1:0]       phase_z;
  logic signed [PROD_W-1:0]   mul_a, rnd, acc;
  logic signed [CORDIC_W-1:0] sx_wide, sy_wide;

  // rounds a CORDIC output from scale 2^30 to Q15, clamped to +-1.0
  function automatic logic signed [TERM_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    begin
      r = (v + 52'sd16384) >>> 15;
      if (r > 52'sd32768) begin
        r = 52'sd32768;
      end else if (r < -52'sd32768) begin
        r = -52'sd32768;
      end
      return TERM_W'(r);
    end
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // input angles reduced to ANGLE_BITS, wrapped difference as 32-bit phase
  always_comb begin
    x_wide  = {16'b0, in_x_angle};
    y_wide  = {16'b0, in_y_angle};
    x_in    = x_wide[AB-1:0];
    y_in    = y_wide[AB-1:0];
    diff    = y_in - x_in;
    phase_z = ZW'($signed({diff, {(32 - AB){1'b0}}}));
  end

  // atan2 operands scaled by 2^16
  always_comb begin
    sx_wide = CORDIC_W'($signed({cosine_sum_r, 16'b0}));
    sy_wide = CORDIC_W'($signed({sine_sum_r, 16'b0}));
  end

  // shared decay multiplier and the round/add/saturate after it
  always_comb begin
    mul_a = (state_r == ST_MUL_C) ? PROD_W'(cosine_sum_r) : PROD_W'(sine_sum_r);
    prod_nxt = mul_a * $signed({{(PROD_W - DECAY_W){1'b0}}, decay_r});
    rnd = (prod_r + 49'sd16384) >>> 15;
    acc = rnd + ((state_r == ST_ADD_C) ? PROD_W'(c_term_r) : PROD_W'(s_term_r));
    if (acc > SUM_MAX) begin
      acc = SUM_MAX;
    end else if (acc < SUM_MIN) begin
      acc = SUM_MIN;
    end
  end

  // final angle, rounded to ANGLE_BITS
  always_comb begin
    z_round   = cz_out[31:0] + ICPT_ROUND;
    pred_sum  = xa_r + icpt_r;
    icpt_wide = {{(32 - AB){1'b0}}, icpt_r};
    pred_wide = {{(32 - AB){1'b0}}, pred_sum};
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    decay_nxt      = decay_r;
    sine_sum_nxt   = sine_sum_r;
    cosine_sum_nxt = cosine_sum_r;
    s_term_nxt     = s_term_r;
    c_term_nxt     = c_term_r;
    xa_nxt         = xa_r;
    icpt_nxt       = icpt_r;
    flip_nxt       = flip_r;
    out_valid_nxt  = out_valid_r;
    out_icpt_nxt   = out_icpt_r;
    out_pred_nxt   = out_pred_r;
    cordic_ctl     = '0;
    cx_init        = CORDIC_X0;
    cy_init        = '0;
    cz_init        = phase_z;

    if (cfg_valid && cfg_ready) begin
      decay_nxt = (cfg_decay > DECAY_ONE) ? DECAY_ONE : cfg_decay;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          xa_nxt = x_in;
          if (in_kind) begin
            state_nxt = ST_VSTART;
          end else begin
            // fold the phase into the CORDIC convergence range
            flip_nxt = 1'b0;
            if (phase_z > 34'sd1073741824) begin
              cz_init  = phase_z - 34'sd2147483648;
              flip_nxt = 1'b1;
            end else if (phase_z < -34'sd1073741824) begin
              cz_init  = phase_z + 34'sd2147483648;
              flip_nxt = 1'b1;
            end
            cordic_ctl.start     = 1'b1;
            cordic_ctl.vectoring = 1'b0;
            state_nxt            = ST_ROT;
          end
        end
      end
      ST_ROT: begin
        if (cordic_sts.done) begin
          c_term_nxt = flip_r ? -to_q15(cx_out) : to_q15(cx_out);
          s_term_nxt = flip_r ? -to_q15(cy_out) : to_q15(cy_out);
          state_nxt  = ST_MUL_S;
        end
      end
      ST_MUL_S: state_nxt = ST_ADD_S;
      ST_ADD_S: begin
        sine_sum_nxt = SUM_W'(acc);
        state_nxt    = ST_MUL_C;
      end
      ST_MUL_C: state_nxt = ST_ADD_C;
      ST_ADD_C: begin
        cosine_sum_nxt = SUM_W'(acc);
        state_nxt      = ST_VSTART;
      end
      ST_VSTART: begin
        if ((sine_sum_r == '0) && (cosine_sum_r == '0)) begin
          icpt_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          // left half plane: negate the vector and start from half a turn
          if (cosine_sum_r[SUM_W-1]) begin
            cx_init = -sx_wide;
            cy_init = -sy_wide;
            cz_init = ZW'(32'h8000_0000);
          end else begin
            cx_init = sx_wide;
            cy_init = sy_wide;
            cz_init = '0;
          end
          cordic_ctl.start     = 1'b1;
          cordic_ctl.vectoring = 1'b1;
          state_nxt            = ST_VEC;
        end
      end
      ST_VEC: begin
        if (cordic_sts.done) begin
          icpt_nxt  = z_round[31 -: AB];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_icpt_nxt  = icpt_wide[ANGLE_FIELD_W-1:0];
          out_pred_nxt  = pred_wide[ANGLE_FIELD_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      decay_r      <= DECAY_RESET;
      sine_sum_r   <= '0;
      cosine_sum_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      decay_r      <= decay_nxt;
      sine_sum_r   <= sine_sum_nxt;
      cosine_sum_r <= cosine_sum_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    s_term_r   <= s_term_nxt;
    c_term_r   <= c_term_nxt;
    prod_r     <= prod_nxt;
    xa_r       <= xa_nxt;
    icpt_r     <= icpt_nxt;
    flip_r     <= flip_nxt;
    out_icpt_r <= out_icpt_nxt;
    out_pred_r <= out_pred_nxt;
  end

  coewma_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cordic_ctl),
    .x_init (cx_init),
    .y_init (cy_init),
    .z_init (cz_init),
    .sts    (cordic_sts),
    .x_out  (cx_out),
    .y_out  (cy_out),
    .z_out  (cz_out)
  );

  assign out_valid       = out_valid_r;
  assign out_intercept   = out_icpt_r;
  assign out_predicted_y = out_pred_r;

  // checks
  `ASSERT_ALWAYS(a_decay_range, decay_r <= DECAY_ONE, "decay above one")
  `ASSERT_IMPLIES(a_cordic_owner, cordic_sts.busy, (state_r == ST_ROT) || (state_r == ST_VEC), "cordic busy outside a pass")
  `ASSERT_NEXT(a_predict_skips, in_acc && in_kind, state_r == ST_VSTART, "predict did not go to atan2")
  `ASSERT_NEXT(a_zero_sums, (state_r == ST_VSTART) && (sine_sum_r == '0) && (cosine_sum_r == '0), (state_r == ST_OUT) && (icpt_r == '0), "zero sums gave nonzero angle")

endmodule

// ----- bench/coewma_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coewma_tb_pkg
// Item kind codes shared by the offset filter checker and its stimulus.
// ----------------------------------------------------------------------------
package coewma_tb_pkg;

  // what an input item asks for
  typedef enum logic {
    KIND_UPDATE  = 1'b0,
    KIND_PREDICT = 1'b1
  } item_kind_e;

endpackage

// ----- bench/coewma_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coewma_checker
// Watches the config, input and result channels of the circular offset
// filter. Keeps its own decayed sine and cosine sums and decay factor, works
// out the intercept and predicted angle for every accepted item, and compares
// each accepted result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module coewma_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [coewma_pkg::DECAY_W-1:0]       cfg_decay,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [coewma_pkg::ANGLE_FIELD_W-1:0] in_x_angle,
  input  logic [coewma_pkg::ANGLE_FIELD_W-1:0] in_y_angle,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [coewma_pkg::ANGLE_FIELD_W-1:0] out_intercept,
  input  logic [coewma_pkg::ANGLE_FIELD_W-1:0] out_predicted_y,
  output int                                   fail_count,
  output int                                   pending
);
  import coewma_pkg::*;
  import coewma_tb_pkg::*;

  localparam int     STEPS      = CORDIC_STEPS_DEF;
  localparam longint QUARTER    = 64'sd1073741824;
  localparam longint HALF       = 64'sd2147483648;
  localparam longint FULL       = 64'sd4294967296;
  localparam longint SUM_MAX    = 64'sd2147483647;
  localparam longint SUM_MIN    = -64'sd2147483648;
  localparam int     PRINT_CAP  = 200;

  typedef struct packed {
    logic [ANGLE_FIELD_W-1:0] intercept;
    logic [ANGLE_FIELD_W-1:0] predicted_y;
  } offset_result_t;

  // micro-rotation angles, atan(2^-i) in 2^-32 turn
  logic [31:0] micro_angle [0:23] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  int             sine_acc;
  int             cosine_acc;
  int             decay_q15;
  offset_result_t offset_due [$];
  offset_result_t seen;
  offset_result_t want;

  function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // sin and cos of a 32-bit phase at scale 2^15, by CORDIC rotation
  function automatic void wrapped_sincos(input logic [31:0] phase,
                                         output longint s, output longint c);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit     flip;
    z = longint'({32'd0, phase});
    if (z >= HALF) z = z - FULL;
    flip = 1'b0;
    x = longint'(CORDIC_X0);
    y = 0;
    // fold the back half-plane onto the front one
    if (z > QUARTER) begin
      z = z - HALF;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z = z + HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'({32'd0, micro_angle[i]});
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'({32'd0, micro_angle[i]});
      end
    end
    x = clamp_range((x + 16384) >>> 15, -32768, 32768);
    y = clamp_range((y + 16384) >>> 15, -32768, 32768);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // heading of the sum vector as a 16-bit binary angle, by CORDIC vectoring
  function automatic logic [ANGLE_FIELD_W-1:0] sum_heading(input int sy, input int cx);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    logic [31:0] z;
    if (sy == 0 && cx == 0) return '0;
    x = longint'(cx) * 65536;
    y = longint'(sy) * 65536;
    z = 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + micro_angle[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - micro_angle[i];
      end
    end
    z = z + (32'd1 << (31 - ANGLE_FIELD_W));
    return z[31 -: ANGLE_FIELD_W];
  endfunction

  // one decay step of a sum, rounded half up, saturating
  function automatic int decay_accumulate(input int sum, input longint term, input int alpha);
    longint p;
    longint v;
    p = longint'(sum) * longint'(alpha);
    v = ((p + 16384) >>> 15) + term;
    return int'(clamp_range(v, SUM_MIN, SUM_MAX));
  endfunction

  // expected result of one item; an update folds the offset into the sums
  function automatic offset_result_t offset_for_item(input logic kind,
                                                     input logic [ANGLE_FIELD_W-1:0] xa,
                                                     input logic [ANGLE_FIELD_W-1:0] ya);
    offset_result_t           r;
    logic [ANGLE_FIELD_W-1:0] diff;
    longint                   s;
    longint                   c;
    if (kind == KIND_UPDATE) begin
      diff = ya - xa;
      wrapped_sincos({diff, 16'h0000}, s, c);
      sine_acc   = decay_accumulate(sine_acc, s, decay_q15);
      cosine_acc = decay_accumulate(cosine_acc, c, decay_q15);
    end
    r.intercept   = sum_heading(sine_acc, cosine_acc);
    r.predicted_y = xa + r.intercept;
    return r;
  endfunction

  task report_mismatch(input string what, input logic [15:0] got_v, input logic [15:0] want_v);
    if (fail_count < PRINT_CAP)
      $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got_v, want_v);
    fail_count++;
  endtask

  // channel monitor: config, then results, then new items
  always @(posedge clk) begin
    if (!rst_n) begin
      sine_acc   = 0;
      cosine_acc = 0;
      decay_q15  = int'(DECAY_RESET);
      offset_due.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        decay_q15 = (cfg_decay > DECAY_ONE) ? int'(DECAY_ONE) : int'(cfg_decay);

      if (out_valid && out_ready) begin
        if (offset_due.size() == 0) begin
          report_mismatch("unexpected result item, intercept", out_intercept, 16'h0000);
        end else begin
          seen.intercept   = out_intercept;
          seen.predicted_y = out_predicted_y;
          want = offset_due.pop_front();
          if (seen.intercept !== want.intercept)
            report_mismatch("intercept", seen.intercept, want.intercept);
          if (seen.predicted_y !== want.predicted_y)
            report_mismatch("predicted_y", seen.predicted_y, want.predicted_y);
        end
      end

      if (in_valid && in_ready)
        offset_due.push_back(offset_for_item(in_kind, in_x_angle, in_y_angle));
    end
    pending = offset_due.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the circular offset EWMA filter: directed edge angles and
// decay settings, then phases of random and offset-tracking items under
// different sender and receiver pacing, one phase with a long result stall.
// The checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import coewma_pkg::*;
  import coewma_tb_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 142;

  typedef enum {
    PACE_FREE,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_e;

  logic                     clk             = 1'b0;
  logic                     rst_n           = 1'b0;
  logic                     cfg_valid       = 1'b0;
  logic                     cfg_ready;
  logic [DECAY_W-1:0]       cfg_decay       = '0;
  logic                     in_valid        = 1'b0;
  logic                     in_ready;
  logic                     in_kind         = 1'b0;
  logic [ANGLE_FIELD_W-1:0] in_x_angle      = '0;
  logic [ANGLE_FIELD_W-1:0] in_y_angle      = '0;
  logic                     out_valid;
  logic                     out_ready       = 1'b0;
  logic [ANGLE_FIELD_W-1:0] out_intercept;
  logic [ANGLE_FIELD_W-1:0] out_predicted_y;

  int                       fail_count;
  int                       pending;
  int                       send_idle_pct   = 0;
  int                       recv_stall_pct  = 0;
  int                       hold_requests   = 0;
  int                       hold_served     = 0;
  int                       hold_left       = 0;
  int                       quiet_cycles    = 0;
  logic [ANGLE_FIELD_W-1:0] track_bias      = '0;

  circular_offset_ewma_filter_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_decay       (cfg_decay),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_x_angle      (in_x_angle),
    .in_y_angle      (in_y_angle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_intercept   (out_intercept),
    .out_predicted_y (out_predicted_y)
  );

  coewma_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_decay       (cfg_decay),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_x_angle      (in_x_angle),
    .in_y_angle      (in_y_angle),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_intercept   (out_intercept),
    .out_predicted_y (out_predicted_y),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: too long without any item moving on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task set_pace(input pace_e pace);
    case (pace)
      PACE_FREE:           begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SENDER_IDLE:    begin send_idle_pct = 71; recv_stall_pct = 0;  end
      PACE_RECEIVER_STALL: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default:             begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  // offer one item, after a random idle gap, and wait for it to be taken
  task send_item(input item_kind_e kind, input logic [15:0] xa, input logic [15:0] ya);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_x_angle <= xa;
    in_y_angle <= ya;
    do @(posedge clk); while (!in_ready);
  endtask

  // drain every result, then write the decay register
  task write_decay(input logic [DECAY_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_decay <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly y tracking x at a fixed offset with small noise, some free angles
  task send_random;
    item_kind_e  kind;
    logic [15:0] xa;
    logic [15:0] ya;
    logic [15:0] noise;
    int          shape;
    kind  = ($urandom_range(99) < 25) ? KIND_PREDICT : KIND_UPDATE;
    xa    = 16'($urandom_range(16'hFFFF));
    noise = 16'($urandom_range(2047));
    shape = $urandom_range(99);
    if (shape < 60) begin
      ya = xa + track_bias + noise - 16'd1024;
    end else if (shape < 85) begin
      ya = 16'($urandom_range(16'hFFFF));
    end else begin
      case ($urandom_range(5))
        0:       begin xa = 16'h0000; ya = 16'hFFFF; end
        1:       begin xa = 16'hFFFF; ya = 16'h0000; end
        2:       begin ya = xa + 16'h4000; end
        3:       begin ya = xa + 16'h8000; end
        4:       begin ya = xa + 16'hC000; end
        default: begin ya = xa; end
      endcase
    end
    send_item(kind, xa, ya);
  endtask

  initial begin
    logic [DECAY_W-1:0] phase_decay;

    set_pace(PACE_FREE);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // both sums still zero after reset
    send_item(KIND_PREDICT, 16'h0000, 16'hFFFF);
    send_item(KIND_PREDICT, 16'hFFFF, 16'h0000);
    // angle extremes and quadrant edges at the reset decay
    send_item(KIND_UPDATE, 16'h0000, 16'h0000);
    send_item(KIND_UPDATE, 16'hFFFF, 16'h0000);
    send_item(KIND_UPDATE, 16'h0000, 16'hFFFF);
    send_item(KIND_UPDATE, 16'h1234, 16'h5234);
    send_item(KIND_UPDATE, 16'h1234, 16'h9234);
    send_item(KIND_UPDATE, 16'h1234, 16'hD234);
    send_item(KIND_UPDATE, 16'h0000, 16'h3FFF);
    send_item(KIND_UPDATE, 16'h0000, 16'h4001);
    send_item(KIND_UPDATE, 16'h8000, 16'hFFFF);
    send_item(KIND_UPDATE, 16'h8000, 16'h0001);
    send_item(KIND_UPDATE, 16'h4000, 16'hFFFF);
    send_item(KIND_UPDATE, 16'h4000, 16'h0001);
    send_item(KIND_PREDICT, 16'hFFFF, 16'h1234);
    send_item(KIND_PREDICT, 16'h8000, 16'hFFFF);
    send_item(KIND_UPDATE, 16'hFFFF, 16'hFFFF);
    send_item(KIND_PREDICT, 16'h5555, 16'hAAAA);

    // unity decay: opposite offsets cancel, leaving the sums as they were
    write_decay(DECAY_ONE);
    send_item(KIND_UPDATE, 16'h0000, 16'h0000);
    send_item(KIND_UPDATE, 16'h0000, 16'h8000);
    send_item(KIND_PREDICT, 16'h1234, 16'h0000);
    // above one clamps to one
    write_decay(16'hFFFF);
    send_item(KIND_UPDATE, 16'h7FFF, 16'h8000);
    send_item(KIND_PREDICT, 16'hFFFF, 16'h0000);
    write_decay(DECAY_RESET);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       phase_decay = DECAY_RESET;
        1:       phase_decay = DECAY_ONE;
        2:       phase_decay = 16'd0;
        3:       phase_decay = 16'hFFFF;
        4:       phase_decay = 16'd1;
        5:       phase_decay = 16'd16384;
        6:       phase_decay = 16'd32767;
        default: phase_decay = DECAY_W'($urandom_range(16'hFFFF));
      endcase
      if (p != 0) write_decay(phase_decay);
      set_pace(pace_e'(p % 4));
      track_bias = ANGLE_FIELD_W'($urandom_range(16'hFFFF));
      // block fills while the result side holds off
      if (p == 4) hold_requests <= hold_requests + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    end

    // wait out the remaining results and the pipeline
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
